// ===== rtl/dsp_pkg.sv =====
// decimal string parser package: word types, character codes, error codes
`default_nettype none

package dsp_pkg;

    localparam int MAX_DIGITS_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam int EXP_W          = 15;
    localparam int DC_W           = 7;

    localparam logic [EXP_W-1:0] EXP_MAX = 15'h7FFF;

    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SYNTAX = 2'd1;
    localparam logic [1:0] ERR_RANGE  = 2'd2;
    localparam logic [1:0] ERR_DIGITS = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic               digit_valid;
        logic [3:0]         digit_value;
        logic               done_res;
        logic               negative;
        logic signed [15:0] scale;
        logic [DC_W-1:0]    digit_count;
        logic [1:0]         error;
    } out_word_t;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_MINUS,
        CLS_POINT,
        CLS_SPACE,
        CLS_EXP,
        CLS_OTHER
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        logic [3:0] value;
        logic       last;
    } tok_t;

endpackage

`default_nettype wire

// ===== rtl/decimal_string_parser_top.sv =====
// decimal string parser top level
// a word waits in the token queue until the grammar step takes it and registers the result
// throughput: one character word per cycle while out_ready keeps the result register free
// a two-entry token queue lets the classifier keep taking words while the result waits
// reset: asynchronous, active low; parser returns to the sign phase, queue and result empty
`default_nettype none

module decimal_string_parser_top #(
    parameter int MAX_DIGITS = dsp_pkg::MAX_DIGITS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire dsp_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output dsp_pkg::out_word_t     out_data
);
    import dsp_pkg::*;

    logic q_ready;
    logic push;
    tok_t push_tok;
    logic pop;
    logic head_valid;
    tok_t head_tok;

    dsp_front u_front (
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_ready  (q_ready),
        .push     (push),
        .push_tok (push_tok)
    );

    dsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_tok   (push_tok),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_tok   (head_tok)
    );

    dsp_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_tok   (head_tok),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/dsp_front.sv =====
// decimal string parser front end: character classification
`default_nettype none

module dsp_front (
    input  wire dsp_pkg::in_word_t in_data,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire                    q_ready,
    output logic                   push,
    output dsp_pkg::tok_t          push_tok
);
    import dsp_pkg::*;

    logic [7:0] digit_off;

    assign in_ready  = q_ready;
    assign push      = in_valid & q_ready;
    assign digit_off = in_data.ch - CH_ZERO;

    always_comb
    begin
        push_tok.last  = in_data.last;
        push_tok.value = 4'd0;
        priority if (in_data.ch >= CH_ZERO && in_data.ch <= CH_NINE)
        begin
            push_tok.cls   = CLS_DIGIT;
            push_tok.value = digit_off[3:0];
        end
        else if (in_data.ch == CH_MINUS)
            push_tok.cls = CLS_MINUS;
        else if (in_data.ch == CH_POINT)
            push_tok.cls = CLS_POINT;
        else if (in_data.ch == CH_SPACE)
            push_tok.cls = CLS_SPACE;
        else if (in_data.ch == CH_E)
            push_tok.cls = CLS_EXP;
        else
            push_tok.cls = CLS_OTHER;
    end

endmodule

`default_nettype wire

// ===== rtl/dsp_queue.sv =====
// decimal string parser token queue between front and back ends
`default_nettype none

module dsp_queue (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  wire dsp_pkg::tok_t push_tok,
    output logic               q_ready,
    input  wire                pop,
    output logic               head_valid,
    output dsp_pkg::tok_t      head_tok
);
    import dsp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign q_ready    = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_tok   = mem_reg[rd_ptr_reg];
    assign do_push    = push & q_ready;
    assign do_pop     = pop & head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dsp_back.sv =====
// decimal string parser back end: grammar state machine and result register
`default_nettype none

module dsp_back #(
    parameter int MAX_DIGITS = dsp_pkg::MAX_DIGITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                head_valid,
    input  wire dsp_pkg::tok_t head_tok,
    output logic               pop,
    output logic               out_valid,
    input  wire                out_ready,
    output dsp_pkg::out_word_t out_data
);
    import dsp_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int SC_W  = ((CNT_W > EXP_W) ? CNT_W : EXP_W) + 2;
    localparam int EP_W  = EXP_W + 4;

    typedef enum logic [2:0] {
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_EXPE,
        PH_ESGN,
        PH_EDIG
    } phase_t;

    phase_t           phase_reg,  phase_next;
    logic             sign_reg,   sign_next;
    logic [CNT_W-1:0] mant_reg,   mant_next;
    logic [CNT_W-1:0] frac_reg,   frac_next;
    logic [EXP_W-1:0] emag_reg,   emag_next;
    logic             eneg_reg,   eneg_next;
    logic [1:0]       err_reg,    err_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_reg,    out_next;

    logic                   take;
    logic                   marker;
    logic                   store;
    logic                   store_frac;
    logic [EP_W-1:0]        exp_sum;
    logic signed [SC_W-1:0] frac_ext;
    logic signed [SC_W-1:0] exp_ext;
    logic signed [SC_W-1:0] sc;
    logic                   sc_ok;
    logic [CNT_W+DC_W-1:0]  cnt_wide;

    assign take      = head_valid & (~out_valid_reg | out_ready);
    assign pop       = take;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign exp_sum = (EP_W'(emag_reg) << 3) + (EP_W'(emag_reg) << 1)
                   + EP_W'(head_tok.value);

    always_comb
    begin
        phase_next     = phase_reg;
        sign_next      = sign_reg;
        mant_next      = mant_reg;
        frac_next      = frac_reg;
        emag_next      = emag_reg;
        eneg_next      = eneg_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_next       = out_reg;
        marker         = 1'b0;
        store          = 1'b0;
        store_frac     = 1'b0;
        frac_ext       = '0;
        exp_ext        = '0;
        sc             = '0;
        sc_ok          = 1'b1;
        cnt_wide       = '0;

        if (take)
        begin
            out_valid_next       = 1'b1;
            out_next             = '0;

            if (err_reg == ERR_NONE)
            begin
                priority if (phase_reg == PH_SIGN && head_tok.cls == CLS_MINUS)
                begin
                    sign_next  = 1'b1;
                    phase_next = PH_INT;
                end
                else if (phase_reg == PH_SIGN || phase_reg == PH_INT)
                begin
                    phase_next = PH_INT;
                    if (head_tok.cls == CLS_POINT)
                        phase_next = PH_FRAC;
                    else if (head_tok.cls == CLS_DIGIT)
                        store = 1'b1;
                    else
                    begin
                        phase_next = PH_EXPE;
                        marker     = 1'b1;
                    end
                end
                else if (phase_reg == PH_FRAC)
                begin
                    if (head_tok.cls == CLS_DIGIT)
                    begin
                        store      = 1'b1;
                        store_frac = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_EXPE;
                        marker     = 1'b1;
                    end
                end
                else if (phase_reg == PH_EXPE)
                    marker = 1'b1;
                else if (phase_reg == PH_ESGN && head_tok.cls == CLS_MINUS)
                begin
                    eneg_next  = 1'b1;
                    phase_next = PH_EDIG;
                end
                else if (phase_reg == PH_ESGN || phase_reg == PH_EDIG)
                begin
                    phase_next = PH_EDIG;
                    if (head_tok.cls == CLS_DIGIT)
                    begin
                        if (exp_sum > EP_W'(EXP_MAX))
                        begin
                            emag_next = EXP_MAX;
                            err_next  = ERR_RANGE;
                        end
                        else
                            emag_next = exp_sum[EXP_W-1:0];
                    end
                    else
                        err_next = ERR_SYNTAX;
                end
                else
                    err_next = ERR_SYNTAX;

                // exponent marker expected: spaces allowed before it
                if (marker)
                begin
                    if (head_tok.cls == CLS_EXP)
                        phase_next = PH_ESGN;
                    else if (head_tok.cls != CLS_SPACE)
                        err_next = ERR_SYNTAX;
                end

                if (store)
                begin
                    if (mant_reg >= CNT_W'(MAX_DIGITS))
                        err_next = ERR_DIGITS;
                    else
                    begin
                        mant_next            = mant_reg + 1'b1;
                        out_next.digit_valid = 1'b1;
                        out_next.digit_value = head_tok.value;
                        if (store_frac)
                            frac_next = frac_reg + 1'b1;
                    end
                end
            end

            if (head_tok.last)
            begin
                frac_ext = SC_W'(frac_next);
                exp_ext  = SC_W'(emag_next);
                sc       = eneg_next ? (frac_ext + exp_ext) : (frac_ext - exp_ext);
                // fits in 16 bits when the upper bits are a pure sign extension
                sc_ok    = (&sc[SC_W-1:15]) | ~(|sc[SC_W-1:15]);
                if (err_next == ERR_NONE && !sc_ok)
                    err_next = ERR_RANGE;
                cnt_wide = (CNT_W+DC_W)'(mant_next);

                out_next.done_res = 1'b1;
                out_next.error    = err_next;
                if (err_next == ERR_NONE)
                begin
                    out_next.negative    = sign_next;
                    out_next.scale       = sc[15:0];
                    out_next.digit_count = cnt_wide[DC_W-1:0];
                end

                phase_next = PH_SIGN;
                sign_next  = 1'b0;
                mant_next  = '0;
                frac_next  = '0;
                emag_next  = '0;
                eneg_next  = 1'b0;
                err_next   = ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIGN;
            sign_reg      <= 1'b0;
            mant_reg      <= '0;
            frac_reg      <= '0;
            emag_reg      <= '0;
            eneg_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            sign_reg      <= sign_next;
            mant_reg      <= mant_next;
            frac_reg      <= frac_next;
            emag_reg      <= emag_next;
            eneg_reg      <= eneg_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

`default_nettype wire
